### rtl/core/ht_rfpc_pkg.sv
package ht_rfpc_pkg;

  localparam int unsigned Subcarriers = 52;
  localparam int unsigned SymSamples  = 80;
  localparam int unsigned ServiceTail = 22;
  localparam int unsigned PreFixed    = 400;
  localparam int unsigned RecipShift  = 24;
  localparam int unsigned Recip3      = 43690;
  localparam int unsigned Recip3Shift = 17;

  typedef struct packed {
    logic [19:0] n2;
    logic [8:0]  base;
    logic [19:0] recip;
    logic [1:0]  shamt;
    logic        div3;
    logic        dbl;
    logic        zero;
    logic [10:0] cbps;
    logic [39:0] prod;
    logic [14:0] q;
    logic [14:0] sym;
  } lane_t;

  typedef struct packed {
    logic        bad;
    logic [2:0]  nss;
    logic [2:0]  bpsc;
    logic [1:0]  rate;
    logic [10:0] dbps;
    logic [10:0] pre;
  } hdr_t;

  typedef struct packed {
    logic [14:0] data_symbols;
    logic [20:0] data_coded_bits;
    logic [20:0] data_samples;
    logic [14:0] meta_symbols;
    logic [20:0] meta_coded_bits;
    logic [20:0] meta_samples;
    logic [10:0] preamble_samples;
    logic [2:0]  spatial_streams;
    logic [2:0]  bits_per_subcarrier;
    logic [1:0]  rate_code;
    logic [10:0] data_bits_per_symbol;
    logic        bad_mode;
  } out_t;

  function automatic logic [2:0] bpsc_lut(input logic [2:0] idx);
    logic [2:0] v;
    unique case (idx)
      3'd0: v = 3'd1;
      3'd1: v = 3'd2;
      3'd2: v = 3'd2;
      3'd3: v = 3'd4;
      3'd4: v = 3'd4;
      3'd5: v = 3'd6;
      3'd6: v = 3'd6;
      3'd7: v = 3'd6;
      default: v = 3'd1;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] rate_lut(input logic [2:0] idx);
    logic [1:0] v;
    unique case (idx)
      3'd0: v = 2'd0;
      3'd1: v = 2'd0;
      3'd2: v = 2'd2;
      3'd3: v = 2'd0;
      3'd4: v = 2'd2;
      3'd5: v = 2'd1;
      3'd6: v = 2'd2;
      3'd7: v = 2'd3;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] dbps_lut(input logic [2:0] idx);
    logic [8:0] v;
    unique case (idx)
      3'd0: v = 9'd26;
      3'd1: v = 9'd52;
      3'd2: v = 9'd78;
      3'd3: v = 9'd104;
      3'd4: v = 9'd156;
      3'd5: v = 9'd208;
      3'd6: v = 9'd234;
      3'd7: v = 9'd260;
      default: v = 9'd26;
    endcase
    return v;
  endfunction

  // Floor of 2^24 over the single-stream data bits per symbol.
  function automatic logic [19:0] recip_lut(input logic [2:0] idx);
    logic [19:0] v;
    unique case (idx)
      3'd0: v = 20'd645277;
      3'd1: v = 20'd322638;
      3'd2: v = 20'd215092;
      3'd3: v = 20'd161319;
      3'd4: v = 20'd107546;
      3'd5: v = 20'd80659;
      3'd6: v = 20'd71697;
      3'd7: v = 20'd64527;
      default: v = 20'd645277;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] dltf_lut(input logic [1:0] idx);
    logic [2:0] v;
    unique case (idx)
      2'd0: v = 3'd1;
      2'd1: v = 3'd2;
      2'd2: v = 3'd4;
      2'd3: v = 3'd4;
      default: v = 3'd1;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] eltf_lut(input logic [1:0] idx);
    logic [2:0] v;
    unique case (idx)
      2'd0: v = 3'd0;
      2'd1: v = 3'd1;
      2'd2: v = 3'd2;
      2'd3: v = 3'd4;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/ht_rx_frame_parameter_calc.sv
// HT receive frame parameter calculator, 20 MHz, 52 data subcarriers.
// Input channel: one receive vector per transaction (data MCS, STBC mode,
// data length, extension streams, meta MCS, meta length) on valid_i, held
// off by stall_o. Output channel: one result per transaction on valid_o,
// held off by stall_i.
// Throughput is one transaction per cycle while the receiver does not
// stall; each symbol count is a pipelined ceiling divide, a reciprocal
// multiply with one correction followed by a divide by the stream
// factor, and the seven register stages set the latency.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// the input is held off only once every stage is full. A stalled result
// stays unchanged on the outputs until it is taken.
// Reset clears all valid bits; no transaction is in flight afterwards.
// An MCS of 32 or above, STBC mode 3, or more than four space-time streams
// sets bad_mode_o and zeroes every other result field.
module ht_rx_frame_parameter_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [6:0]  data_mcs_i,
  input  logic [1:0]  stbc_mode_i,
  input  logic [15:0] data_length_i,
  input  logic [1:0]  ext_streams_i,
  input  logic [6:0]  meta_mcs_i,
  input  logic [15:0] meta_length_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [14:0] data_symbols_o,
  output logic [20:0] data_coded_bits_o,
  output logic [20:0] data_samples_o,
  output logic [14:0] meta_symbols_o,
  output logic [20:0] meta_coded_bits_o,
  output logic [20:0] meta_samples_o,
  output logic [10:0] preamble_samples_o,
  output logic [2:0]  spatial_streams_o,
  output logic [2:0]  bits_per_subcarrier_o,
  output logic [1:0]  rate_code_o,
  output logic [10:0] data_bits_per_symbol_o,
  output logic        bad_mode_o
);

  localparam int unsigned NumStages  = 7;
  localparam int unsigned LaneStages = NumStages - 1;
  localparam int unsigned NumLanes   = 2;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  ht_rfpc_pkg::lane_t ln_q [LaneStages][NumLanes];
  ht_rfpc_pkg::lane_t ln_d [LaneStages][NumLanes];
  ht_rfpc_pkg::hdr_t  hdr_q [LaneStages];
  ht_rfpc_pkg::hdr_t  hdr_d;
  ht_rfpc_pkg::out_t  out_q;
  ht_rfpc_pkg::out_t  out_d;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !stall_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[NumStages-1];

  always_comb begin
    logic [6:0]  mcs;
    logic [15:0] len;
    logic [2:0]  nss;
    logic [2:0]  bpsc;
    logic [10:0] dbps;
    logic [11:0] den;
    logic [1:0]  sh;
    logic [2:0]  dnss;
    logic [3:0]  nsts;
    logic [3:0]  ltf;
    logic [14:0] q0;
    logic [23:0] r;
    logic [14:0] q1;
    logic [14:0] q3;
    logic [16:0] r3;
    logic [14:0] qc;
    logic [14:0] qd;

    for (int l = 0; l < NumLanes; l++) begin
      mcs  = (l == 0) ? data_mcs_i : meta_mcs_i;
      len  = (l == 0) ? data_length_i : meta_length_i;
      nss  = {1'b0, mcs[4:3]} + 3'd1;
      bpsc = ht_rfpc_pkg::bpsc_lut(mcs[2:0]);
      dbps = 11'(ht_rfpc_pkg::dbps_lut(mcs[2:0])) * 11'(nss);
      ln_d[0][l]       = '0;
      ln_d[0][l].dbl   = (l == 0) && (stbc_mode_i != 2'd0);
      ln_d[0][l].zero  = (len == 16'd0);
      ln_d[0][l].base  = ht_rfpc_pkg::dbps_lut(mcs[2:0]);
      ln_d[0][l].recip = ht_rfpc_pkg::recip_lut(mcs[2:0]);
      ln_d[0][l].cbps  = 11'(ht_rfpc_pkg::Subcarriers) * 11'(bpsc) * 11'(nss);
      den = ln_d[0][l].dbl ? {dbps, 1'b0} : {1'b0, dbps};
      ln_d[0][l].n2 = 20'({len, 3'b000}) + 20'(ht_rfpc_pkg::ServiceTail)
                    + 20'(den) - 20'd1;
      unique case (mcs[4:3])
        2'd0: begin
          sh = 2'd0;
          ln_d[0][l].div3 = 1'b0;
        end
        2'd1: begin
          sh = 2'd1;
          ln_d[0][l].div3 = 1'b0;
        end
        2'd2: begin
          sh = 2'd0;
          ln_d[0][l].div3 = 1'b1;
        end
        2'd3: begin
          sh = 2'd2;
          ln_d[0][l].div3 = 1'b0;
        end
        default: begin
          sh = 2'd0;
          ln_d[0][l].div3 = 1'b0;
        end
      endcase
      ln_d[0][l].shamt = sh + 2'(ln_d[0][l].dbl);

      ln_d[1][l] = ln_q[0][l];
      ln_d[1][l].prod = 40'(ln_q[0][l].n2) * 40'(ln_q[0][l].recip);

      q0 = ln_q[1][l].prod[ht_rfpc_pkg::RecipShift+14:ht_rfpc_pkg::RecipShift];
      ln_d[2][l] = ln_q[1][l];
      ln_d[2][l].q = q0;
      ln_d[2][l].prod = 40'(24'(q0) * 24'(ln_q[1][l].base));

      r  = 24'(ln_q[2][l].n2) - ln_q[2][l].prod[23:0];
      q1 = ln_q[2][l].q + 15'(r >= 24'(ln_q[2][l].base));
      ln_d[3][l] = ln_q[2][l];
      ln_d[3][l].q = q1 >> ln_q[2][l].shamt;

      ln_d[4][l] = ln_q[3][l];
      ln_d[4][l].prod = 40'(32'(ln_q[3][l].q) * 32'(ht_rfpc_pkg::Recip3));

      q3 = ln_q[4][l].prod[ht_rfpc_pkg::Recip3Shift+14:ht_rfpc_pkg::Recip3Shift];
      r3 = 17'(ln_q[4][l].q) - (17'({q3, 1'b0}) + 17'(q3));
      qc = q3 + 15'(r3 >= 17'd3);
      qd = ln_q[4][l].div3 ? qc : ln_q[4][l].q;
      ln_d[5][l] = ln_q[4][l];
      if (ln_q[4][l].zero) begin
        ln_d[5][l].sym = '0;
      end else if (ln_q[4][l].dbl) begin
        ln_d[5][l].sym = {qd[13:0], 1'b0};
      end else begin
        ln_d[5][l].sym = qd;
      end
    end

    dnss = {1'b0, data_mcs_i[4:3]} + 3'd1;
    nsts = 4'(dnss) + 4'(stbc_mode_i);
    ltf  = 4'(ht_rfpc_pkg::dltf_lut(2'(nsts - 4'd1)))
         + 4'(ht_rfpc_pkg::eltf_lut(ext_streams_i)) + 4'd1;
    hdr_d.bad  = (data_mcs_i[6:5] != 2'd0) || (meta_mcs_i[6:5] != 2'd0)
              || (stbc_mode_i == 2'd3) || (nsts > 4'd4);
    hdr_d.nss  = dnss;
    hdr_d.bpsc = ht_rfpc_pkg::bpsc_lut(data_mcs_i[2:0]);
    hdr_d.rate = ht_rfpc_pkg::rate_lut(data_mcs_i[2:0]);
    hdr_d.dbps = 11'(ht_rfpc_pkg::dbps_lut(data_mcs_i[2:0])) * 11'(dnss);
    hdr_d.pre  = 11'(ltf) * 11'(ht_rfpc_pkg::SymSamples) + 11'(ht_rfpc_pkg::PreFixed);
  end

  always_comb begin
    out_d = '0;
    if (hdr_q[LaneStages-1].bad) begin
      out_d.bad_mode = 1'b1;
    end else begin
      out_d.data_symbols    = ln_q[LaneStages-1][0].sym;
      out_d.data_coded_bits = 21'(26'(ln_q[LaneStages-1][0].sym)
                            * 26'(ln_q[LaneStages-1][0].cbps));
      out_d.data_samples    = 21'(22'(ln_q[LaneStages-1][0].sym)
                            * 22'(ht_rfpc_pkg::SymSamples));
      out_d.meta_symbols    = ln_q[LaneStages-1][1].sym;
      out_d.meta_coded_bits = 21'(26'(ln_q[LaneStages-1][1].sym)
                            * 26'(ln_q[LaneStages-1][1].cbps));
      out_d.meta_samples    = 21'(22'(ln_q[LaneStages-1][1].sym)
                            * 22'(ht_rfpc_pkg::SymSamples));
      out_d.preamble_samples     = hdr_q[LaneStages-1].pre;
      out_d.spatial_streams      = hdr_q[LaneStages-1].nss;
      out_d.bits_per_subcarrier  = hdr_q[LaneStages-1].bpsc;
      out_d.rate_code            = hdr_q[LaneStages-1].rate;
      out_d.data_bits_per_symbol = hdr_q[LaneStages-1].dbps;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (en[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hdr_q[0] <= hdr_d;
    end
    for (int s = 0; s < LaneStages; s++) begin
      if (en[s]) begin
        for (int l = 0; l < NumLanes; l++) begin
          ln_q[s][l] <= ln_d[s][l];
        end
      end
    end
    for (int s = 1; s < LaneStages; s++) begin
      if (en[s]) begin
        hdr_q[s] <= hdr_q[s-1];
      end
    end
    if (en[NumStages-1]) begin
      out_q <= out_d;
    end
  end

  assign data_symbols_o         = out_q.data_symbols;
  assign data_coded_bits_o      = out_q.data_coded_bits;
  assign data_samples_o         = out_q.data_samples;
  assign meta_symbols_o         = out_q.meta_symbols;
  assign meta_coded_bits_o      = out_q.meta_coded_bits;
  assign meta_samples_o         = out_q.meta_samples;
  assign preamble_samples_o     = out_q.preamble_samples;
  assign spatial_streams_o      = out_q.spatial_streams;
  assign bits_per_subcarrier_o  = out_q.bits_per_subcarrier;
  assign rate_code_o            = out_q.rate_code;
  assign data_bits_per_symbol_o = out_q.data_bits_per_symbol;
  assign bad_mode_o             = out_q.bad_mode;

  // The input is held off only while the first stage holds a transaction.
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> vld_q[0])
    else $error("stall_o raised with an empty first stage");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_bad_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bad_mode_o) |-> (data_symbols_o == '0 && meta_symbols_o == '0
      && preamble_samples_o == '0 && spatial_streams_o == '0))
    else $error("bad mode result carries nonzero fields");

  a_preamble_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !bad_mode_o) |-> (preamble_samples_o >= 11'd560
      && preamble_samples_o <= 11'd1120))
    else $error("preamble sample count out of range");

endmodule
